### hw/rtl/ptwc_pkg.sv
package ptwc_pkg;

  localparam int unsigned IDX_W   = 9;
  localparam int unsigned PAGE_W  = 6;
  localparam int unsigned VA_W    = 48;
  localparam int unsigned DESC_W  = 64;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned BASE_W  = 36;
  localparam int unsigned FREE_W  = 7;
  localparam int unsigned PN_W    = 52;  // descriptor bits 63:12
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 36;

  localparam int unsigned LAST_LVL = 3;

  typedef enum logic [1:0] {
    REQ_WALK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNMAPPED  = 2'd1,
    ST_NO_PAGES  = 2'd2,
    ST_OUTSIDE   = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STORE_BASE = 2'd0,
    CFG_ROOT_PAGE  = 2'd1,
    CFG_FIRST_FREE = 2'd2
  } cfg_idx_e;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_START = 6'b000100,
    S_RD    = 6'b001000,
    S_EVAL  = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  // table index used at a given level of the walk
  function automatic logic [IDX_W-1:0] walk_index(input logic [VA_W-1:0] va,
                                                  input logic [1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

### hw/rtl/ptwc_req_if.sv
interface ptwc_req_if import ptwc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          req_type;
  logic [VA_W-1:0]     virt_addr;
  logic                create;
  logic [PAGE_W-1:0]   page_sel;
  logic [IDX_W-1:0]    entry_sel;
  logic [DESC_W-1:0]   write_value;

  modport source (output valid, req_type, virt_addr, create, page_sel, entry_sel,
                  write_value, input ready);
  modport sink (input valid, req_type, virt_addr, create, page_sel, entry_sel,
                write_value, output ready);
endinterface

### hw/rtl/ptwc_rsp_if.sv
interface ptwc_rsp_if import ptwc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [PAGE_W-1:0]   leaf_page;
  logic [IDX_W-1:0]    leaf_entry;
  logic [DESC_W-1:0]   entry_value;
  logic [COUNT_W-1:0]  pages_given;

  modport source (output valid, status, leaf_page, leaf_entry, entry_value, pages_given,
                  input ready);
  modport sink (input valid, status, leaf_page, leaf_entry, entry_value, pages_given,
                output ready);
endinterface

### hw/rtl/page_table_walker_with_create_unit.sv
// Four-level page table walker (4 KiB granule, 48-bit VA) over an on-chip table
// store of TABLE_PAGES pages x 512 descriptors, held in one single-port
// synchronous RAM. After reset the RAM is zeroed by a sweep over all TABLE_PAGES*512
// entries, during which no request is taken; config writes are taken at any time.
// One request is processed at a time; a walk does one dependent RAM read per level
// visited. A missing table with create set is allocated and its descriptor written
// back in the same level step. The result sits in an output register, so the next
// request is accepted while it waits.
module page_table_walker_with_create_unit import ptwc_pkg::*; #(
  parameter int unsigned TABLE_PAGES = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ptwc_req_if.sink              req_i,
  ptwc_rsp_if.source            rsp_o
);

  localparam int unsigned PW    = $clog2(TABLE_PAGES);
  localparam int unsigned PGW   = (PW > PAGE_W) ? PW : PAGE_W;
  localparam int unsigned AW    = PW + IDX_W;
  localparam int unsigned DEPTH = TABLE_PAGES * (2 ** IDX_W);
  localparam int unsigned CNTW  = $clog2(TABLE_PAGES + 1);
  localparam int unsigned ACW   = (CNTW > COUNT_W) ? CNTW : COUNT_W;
  localparam int unsigned NW    = ACW + 1;

  // configuration
  logic [BASE_W-1:0] base_q;
  logic [PAGE_W-1:0] root_q;
  logic [FREE_W-1:0] ffree_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      root_q  <= '0;
      ffree_q <= FREE_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STORE_BASE: base_q  <= cfg_data_i[BASE_W-1:0];
        CFG_ROOT_PAGE:  root_q  <= cfg_data_i[PAGE_W-1:0];
        CFG_FIRST_FREE: ffree_q <= cfg_data_i[FREE_W-1:0];
        default: ;
      endcase
    end
  end

  // latched request
  logic [1:0]        op_q;
  logic [VA_W-1:0]   va_q;
  logic              create_q;
  logic [PAGE_W-1:0] psel_q;
  logic [IDX_W-1:0]  esel_q;
  logic [DESC_W-1:0] wval_q;

  state_e            state_q, state_d;
  logic [PGW-1:0]    page_q, page_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [1:0]        lvl_q, lvl_d;
  logic [ACW-1:0]    alloc_q, alloc_d;
  logic [AW-1:0]     clr_q;

  logic [1:0]        res_status_q, res_status_d;
  logic [PAGE_W-1:0] res_page_q, res_page_d;
  logic [IDX_W-1:0]  res_entry_q, res_entry_d;
  logic [DESC_W-1:0] res_val_q, res_val_d;

  logic              out_valid_q;
  logic [1:0]        out_status_q;
  logic [PAGE_W-1:0] out_page_q;
  logic [IDX_W-1:0]  out_entry_q;
  logic [DESC_W-1:0] out_val_q;
  logic [COUNT_W-1:0] out_given_q;

  // table store
  logic [DESC_W-1:0] mem_q [DEPTH];
  logic [DESC_W-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_addr;
  logic [DESC_W-1:0] mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= mem_wdata;
    if (mem_re) rdata_q <= mem_q[mem_addr];
  end

  logic              req_fire;
  logic              out_free;
  logic [NW-1:0]     next_page;
  logic [PN_W:0]     rel;
  logic              rel_outside;
  logic [PGW-1:0]    psel_ext;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign psel_ext    = PGW'(psel_q);
  assign next_page   = NW'(ffree_q) + NW'(alloc_q);
  assign rel         = {1'b0, rdata_q[DESC_W-1:DESC_W-PN_W]} - (PN_W+1)'(base_q);
  assign rel_outside = rel[PN_W] || (rel[PN_W-1:0] >= PN_W'(TABLE_PAGES));

  always_comb begin
    state_d      = state_q;
    page_d       = page_q;
    idx_d        = idx_q;
    lvl_d        = lvl_q;
    alloc_d      = alloc_q;
    res_status_d = res_status_q;
    res_page_d   = res_page_q;
    res_entry_d  = res_entry_q;
    res_val_d    = res_val_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_addr     = {page_q[PW-1:0], idx_q};
    mem_wdata    = '0;

    case (state_q)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
        if (clr_q == AW'(DEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_fire) state_d = S_START;
      end
      S_START: begin
        state_d = S_RESP;
        case (op_q)
          REQ_WALK: begin
            if (32'(root_q) >= 32'(TABLE_PAGES)) begin
              res_status_d = ST_OUTSIDE;
              res_page_d   = root_q;
              res_entry_d  = walk_index(va_q, 2'd0);
              res_val_d    = '0;
            end else begin
              page_d  = PGW'(root_q);
              idx_d   = walk_index(va_q, 2'd0);
              lvl_d   = 2'd0;
              state_d = S_RD;
            end
          end
          REQ_WRITE, REQ_READ: begin
            res_page_d  = psel_q;
            res_entry_d = esel_q;
            if (32'(psel_q) >= 32'(TABLE_PAGES)) begin
              res_status_d = ST_OUTSIDE;
              res_val_d    = '0;
            end else if (op_q == REQ_WRITE) begin
              mem_we       = 1'b1;
              mem_addr     = {psel_ext[PW-1:0], esel_q};
              mem_wdata    = wval_q;
              res_status_d = ST_OK;
              res_val_d    = wval_q;
            end else begin
              page_d  = psel_ext;
              idx_d   = esel_q;
              state_d = S_RD;
            end
          end
          default: begin
            res_status_d = ST_OK;
            res_page_d   = '0;
            res_entry_d  = '0;
            res_val_d    = '0;
          end
        endcase
      end
      S_RD: begin
        mem_re  = 1'b1;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        res_page_d  = page_q[PAGE_W-1:0];
        res_entry_d = idx_q;
        res_val_d   = rdata_q;
        state_d     = S_RESP;
        if (op_q != REQ_WALK || lvl_q == 2'(LAST_LVL)) begin
          res_status_d = ST_OK;
        end else if (!rdata_q[0]) begin
          if (!create_q) begin
            res_status_d = ST_UNMAPPED;
          end else if (next_page >= NW'(TABLE_PAGES)) begin
            res_status_d = ST_NO_PAGES;
          end else begin
            // fresh table: link it in and descend; it is already zero
            mem_we    = 1'b1;
            mem_wdata = {PN_W'(base_q) + PN_W'(next_page), 12'h003};
            alloc_d   = ACW'(alloc_q + 1'b1);
            page_d    = PGW'(next_page);
            idx_d     = walk_index(va_q, 2'(lvl_q + 2'd1));
            lvl_d     = 2'(lvl_q + 2'd1);
            state_d   = S_RD;
          end
        end else if (rel_outside) begin
          res_status_d = ST_OUTSIDE;
        end else begin
          page_d  = PGW'(rel[PN_W-1:0]);
          idx_d   = walk_index(va_q, 2'(lvl_q + 2'd1));
          lvl_d   = 2'(lvl_q + 2'd1);
          state_d = S_RD;
        end
      end
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      alloc_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      alloc_q <= alloc_d;
      if (state_q == S_CLEAR) clr_q <= AW'(clr_q + 1'b1);
      if (state_q == S_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    page_q       <= page_d;
    idx_q        <= idx_d;
    lvl_q        <= lvl_d;
    res_status_q <= res_status_d;
    res_page_q   <= res_page_d;
    res_entry_q  <= res_entry_d;
    res_val_q    <= res_val_d;
    if (req_fire) begin
      op_q     <= req_i.req_type;
      va_q     <= req_i.virt_addr;
      create_q <= req_i.create;
      psel_q   <= req_i.page_sel;
      esel_q   <= req_i.entry_sel;
      wval_q   <= req_i.write_value;
    end
    if (state_q == S_RESP && out_free) begin
      out_status_q <= res_status_q;
      out_page_q   <= res_page_q;
      out_entry_q  <= res_entry_q;
      out_val_q    <= res_val_q;
      out_given_q  <= alloc_q[COUNT_W-1:0];
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.leaf_page   = out_page_q;
  assign rsp_o.leaf_entry  = out_entry_q;
  assign rsp_o.entry_value = out_val_q;
  assign rsp_o.pages_given = out_given_q;

  // allocator only moves by one, and only while evaluating a walk level
  a_alloc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (alloc_q != $past(alloc_q)) |->
      ($past(state_q) == S_EVAL) && (alloc_q == ACW'($past(alloc_q) + 1'b1)))
    else $error("allocator count changed outside a level step");

  a_rd_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> (32'(page_q) < 32'(TABLE_PAGES)))
    else $error("table read outside the store");

  a_rsp_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_RESP))
    else $error("response raised without a finished request");

  a_clear_no_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |=> !out_valid_q)
    else $error("response during store clear");

endmodule
